// ===== hdl/pic_pkg.sv =====
// shared types and constants of the prescaled interrupt counter
package pic_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CPU   = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_PPU   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_MODE   = 3'd1,
    REG_IRQ_OFF = 3'd2,
    REG_IRQ_ON = 3'd3,
    REG_PRESC  = 3'd4,
    REG_COUNT  = 3'd5,
    REG_XOR    = 3'd6,
    REG_PSIZE  = 3'd7
  } reg_sel_e;

  typedef enum logic [1:0] {
    SRC_CPU  = 2'd0,
    SRC_LINE = 2'd1,
    SRC_PPU  = 2'd2,
    SRC_NONE = 2'd3
  } src_e;

  localparam logic [1:0] DirUp   = 2'd1;
  localparam logic [1:0] DirDown = 2'd2;

  localparam logic [7:0] MaskNarrow   = 8'h07;
  localparam logic [7:0] MaskWide     = 8'hFF;
  localparam logic [3:0] MaxCpuClocks = 4'd8;
  localparam logic [3:0] PpuClocks    = 4'd2;

  // decoded work of one item for the timer core
  typedef struct packed {
    logic        wr_en;
    reg_sel_e    sel;
    logic [7:0]  data;
    logic [3:0]  ticks;
    logic        ppu_upd;
    logic [13:0] ppu_addr;
  } pic_evt_t;

endpackage

// ===== hdl/pic_evt_decode.sv =====
// turns one item into a register write or a number of timer clocks
module pic_evt_decode import pic_pkg::*; #(
  parameter int LINE_CLOCKS = 8
) (
  input  cmd_e        command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [3:0]  cycle_count_i,
  input  src_e        source_i,
  input  logic [13:0] last_ppu_i,
  output pic_evt_t    evt_o
);

  localparam logic [3:0] LineTicks = 4'(LINE_CLOCKS);

  logic [13:0] ppu_addr;

  assign ppu_addr = address_i[13:0];

  always_comb begin
    evt_o          = '0;
    evt_o.sel      = reg_sel_e'(address_i[2:0]);
    evt_o.data     = write_data_i;
    evt_o.ppu_addr = ppu_addr;
    unique case (command_i)
      CMD_WRITE: begin
        evt_o.wr_en = 1'b1;
      end
      CMD_CPU: begin
        if (source_i == SRC_CPU) begin
          evt_o.ticks = (cycle_count_i > MaxCpuClocks) ? MaxCpuClocks : cycle_count_i;
        end
      end
      CMD_LINE: begin
        if (source_i == SRC_LINE) begin
          evt_o.ticks = LineTicks;
        end
      end
      CMD_PPU: begin
        if (source_i == SRC_PPU) begin
          evt_o.ppu_upd = 1'b1;
          if (ppu_addr != last_ppu_i) begin
            evt_o.ticks = PpuClocks;
          end
        end
      end
      default: begin
        evt_o.wr_en = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/pic_timer.sv =====
// timer state, register writes and the prescaler and counter steps
module pic_timer import pic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  pic_evt_t    evt_i,
  output src_e        source_o,
  output logic [13:0] last_ppu_o,
  output logic        irq_next_o
);

  logic [7:0]  mode_q, mode_d;
  logic [7:0]  presc_q, presc_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  psize_q, psize_d;
  logic        enable_q, enable_d;
  logic        pending_q, pending_d;
  logic [13:0] last_ppu_q, last_ppu_d;

  logic [1:0] dir;
  logic [7:0] mask;
  logic [7:0] low;
  logic [8:0] low_sum;
  logic       wrap_up;
  logic       wrap_dn;

  assign dir  = mode_q[7:6];
  assign mask = mode_q[2] ? MaskNarrow : MaskWide;
  assign low  = presc_q & mask;

  // each item counts at most one prescaler wrap, at either mask
  assign low_sum = {1'b0, low} + {5'b0, evt_i.ticks};
  assign wrap_up = low_sum > {1'b0, mask};
  assign wrap_dn = low < {4'b0, evt_i.ticks};

  always_comb begin
    mode_d     = mode_q;
    presc_d    = presc_q;
    count_d    = count_q;
    xor_d      = xor_q;
    psize_d    = psize_q;
    enable_d   = enable_q;
    pending_d  = pending_q;
    last_ppu_d = last_ppu_q;
    if (evt_i.wr_en) begin
      unique case (evt_i.sel)
        REG_ENABLE: begin
          enable_d = evt_i.data[0];
          if (!evt_i.data[0]) begin
            pending_d = 1'b0;
          end
        end
        REG_MODE:    mode_d  = evt_i.data;
        REG_IRQ_OFF: begin
          enable_d  = 1'b0;
          pending_d = 1'b0;
        end
        REG_IRQ_ON:  enable_d = 1'b1;
        REG_PRESC:   presc_d  = evt_i.data ^ xor_q;
        REG_COUNT:   count_d  = evt_i.data ^ xor_q;
        REG_XOR:     xor_d    = evt_i.data;
        REG_PSIZE:   psize_d  = evt_i.data;
        default:     psize_d  = psize_q;
      endcase
    end else begin
      if (evt_i.ppu_upd) begin
        last_ppu_d = evt_i.ppu_addr;
      end
      if (dir == DirUp) begin
        presc_d = presc_q + {4'b0, evt_i.ticks};
        if (wrap_up) begin
          count_d = count_q + 8'd1;
          if (count_q == 8'hFF && enable_q) begin
            pending_d = 1'b1;
          end
        end
      end else if (dir == DirDown) begin
        presc_d = presc_q - {4'b0, evt_i.ticks};
        if (wrap_dn) begin
          count_d = count_q - 8'd1;
          if (count_q == 8'h00 && enable_q) begin
            pending_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      presc_q    <= '0;
      count_q    <= '0;
      xor_q      <= '0;
      psize_q    <= '0;
      enable_q   <= 1'b0;
      pending_q  <= 1'b0;
      last_ppu_q <= '0;
    end else if (step_en_i) begin
      mode_q     <= mode_d;
      presc_q    <= presc_d;
      count_q    <= count_d;
      xor_q      <= xor_d;
      psize_q    <= psize_d;
      enable_q   <= enable_d;
      pending_q  <= pending_d;
      last_ppu_q <= last_ppu_d;
    end
  end

  assign source_o   = src_e'(mode_q[1:0]);
  assign last_ppu_o = last_ppu_q;
  assign irq_next_o = pending_d;

endmodule

// ===== hdl/prescaled_irq_counter.sv =====
// prescaled up/down interrupt counter: input stage, timer core, result register
// irq_line_o is registered: an item passes the input register, then the timer core
//   and the result register, and a stalled full result register holds it back
// throughput: one item per cycle; the input register and result register
//   decouple the two channels, only a stalled full result register stalls input
// reset (rst_ni, async active low) clears mode, prescaler, counter, xor value,
//   prescale size, enable, pending interrupt and the last ppu address
module prescaled_irq_counter import pic_pkg::*; #(
  parameter int LINE_CLOCKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [3:0]  cycle_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        irq_line_o
);

  // input stage holds one item until the timer core takes it
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_cmd_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic [3:0]  s1_count_q;

  // result register
  logic out_valid_q, out_valid_d;
  logic out_irq_q;

  logic        advance;
  logic        in_xfer;
  pic_evt_t    evt;
  src_e        source;
  logic [13:0] last_ppu;
  logic        irq_next;

  // the core runs when it holds an item and the result register is free or being drained
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  pic_evt_decode #(
    .LINE_CLOCKS (LINE_CLOCKS)
  ) u_decode (
    .command_i     (cmd_e'(s1_cmd_q)),
    .address_i     (s1_addr_q),
    .write_data_i  (s1_data_q),
    .cycle_count_i (s1_count_q),
    .source_i      (source),
    .last_ppu_i    (last_ppu),
    .evt_o         (evt)
  );

  pic_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (advance),
    .evt_i      (evt),
    .source_o   (source),
    .last_ppu_o (last_ppu),
    .irq_next_o (irq_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, loaded on transfer only
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q   <= command_i;
      s1_addr_q  <= address_i;
      s1_data_q  <= write_data_i;
      s1_count_q <= cycle_count_i;
    end
    if (advance) begin
      out_irq_q <= irq_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign irq_line_o  = out_irq_q;

endmodule

// ===== hdl/pic_checker.sv =====
// port-level checks of the prescaled interrupt counter and their binding
module pic_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic irq_line_o
);

  // input only backs up behind a full, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side can move");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(irq_line_o)))
    else $error("stalled result changed");

  // with no new items and a free result side held throughout the sequence, no result
  // is left valid after it
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
      ##1 (!in_valid_i && !out_stall_i) |=> !out_valid_o)
    else $error("result invented or held after drain");

endmodule

bind prescaled_irq_counter pic_checker u_pic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .irq_line_o  (irq_line_o)
);
